// ===== rtl/core/mpsa_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsa_pkg
// Shared types and codes of the multi-pool slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package mpsa_pkg;

    // field widths
    localparam int MODE_W   = 3;
    localparam int SIZE_W   = 16;
    localparam int POOL_W   = 3;
    localparam int SLOT_W   = 8;
    localparam int STAT_W   = 3;
    localparam int OFF_W    = 22;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 56;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REG_POOLS = 4;

    localparam logic [SIZE_W-1:0] FREE_MARK = 16'hFFFF;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_RESERVE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR_POOL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR_ALL  = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_STORE_FULL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_ILLEGAL_ID  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_PRESENT = 3'd4;

    // register indexes
    localparam logic [2:0] REG_POOL_COUNT  = 3'd0;
    localparam logic [2:0] REG_SPILL       = 3'd1;
    localparam logic [2:0] REG_BLOCK_0     = 3'd2;
    localparam logic [2:0] REG_BLOCK_1     = 3'd3;
    localparam logic [2:0] REG_BLOCK_2     = 3'd4;
    localparam logic [2:0] REG_BLOCK_3     = 3'd5;
    localparam logic [2:0] REG_SLOT_COUNTS = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]                      pool_count;
        logic                            spill_enable;
        logic [REG_POOLS-1:0][SIZE_W-1:0] block_size;
        logic [31:0]                     slot_counts;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic step;
        logic rd;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] in_mode;
        logic              search_stop;
        logic              out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/mpsa_cfg.sv =====
// ----------------------------------------------------------------------------
// mpsa_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsa_cfg (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mpsa_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mpsa_pkg::DATA_W-1:0] pwdata,
    output logic      [mpsa_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output mpsa_pkg::cfg_t                  cfg
);
    import mpsa_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_POOL_COUNT:  cfg_next.pool_count    = pwdata[2:0];
                REG_SPILL:       cfg_next.spill_enable  = pwdata[0];
                REG_BLOCK_0:     cfg_next.block_size[0] = pwdata[15:0];
                REG_BLOCK_1:     cfg_next.block_size[1] = pwdata[15:0];
                REG_BLOCK_2:     cfg_next.block_size[2] = pwdata[15:0];
                REG_BLOCK_3:     cfg_next.block_size[3] = pwdata[15:0];
                REG_SLOT_COUNTS: cfg_next.slot_counts   = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pool_count    <= 3'd4;
            cfg_reg.spill_enable  <= 1'b0;
            cfg_reg.block_size[0] <= 16'd16;
            cfg_reg.block_size[1] <= 16'd32;
            cfg_reg.block_size[2] <= 16'd64;
            cfg_reg.block_size[3] <= 16'd128;
            cfg_reg.slot_counts   <= 32'h4040_4040;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // register read mux
    always_comb begin
        unique case (reg_idx)
            REG_POOL_COUNT:  prdata = {29'd0, cfg_reg.pool_count};
            REG_SPILL:       prdata = {31'd0, cfg_reg.spill_enable};
            REG_BLOCK_0:     prdata = {16'd0, cfg_reg.block_size[0]};
            REG_BLOCK_1:     prdata = {16'd0, cfg_reg.block_size[1]};
            REG_BLOCK_2:     prdata = {16'd0, cfg_reg.block_size[2]};
            REG_BLOCK_3:     prdata = {16'd0, cfg_reg.block_size[3]};
            REG_SLOT_COUNTS: prdata = cfg_reg.slot_counts;
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/mpsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpsa_ctrl
// Sequencer: accept, pool search or table read where needed, then result hand-over.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsa_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  mpsa_pkg::stat_t      stat,
    output mpsa_pkg::cmd_t       cmd
);
    import mpsa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (stat.in_mode == MODE_RESERVE) begin
                        state_next = ST_SEARCH;
                    end else if (stat.in_mode == MODE_LOOKUP) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SEARCH: begin
                cmd.step = 1'b1;
                if (stat.search_stop) begin
                    state_next = ST_DONE;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/mpsa_dp.sv =====
// ----------------------------------------------------------------------------
// mpsa_dp
// Datapath: occupancy bits, size table, pool search and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsa_dp #(
    parameter int POOLS = 4,
    parameter int SLOTS = 64
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  mpsa_pkg::cfg_t                  cfg,
    input  mpsa_pkg::cmd_t                  cmd,
    output mpsa_pkg::stat_t                 stat,
    input  wire logic [mpsa_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [mpsa_pkg::OUT_W-1:0] m_tdata
);
    import mpsa_pkg::*;

    localparam int PW    = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH = POOLS * SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NPMAX = (POOLS < REG_POOLS) ? POOLS : REG_POOLS;

    // slot count of one pool, capped at SLOTS
    function automatic logic [8:0] slots_of(input logic [31:0] counts,
                                            input logic [1:0] p);
        logic [8:0] n;
        n = {1'b0, counts[8*p +: 8]};
        if (n > 9'(SLOTS)) n = 9'(SLOTS);
        return n;
    endfunction

    // latched item
    logic [MODE_W-1:0] mode_reg;
    logic [SIZE_W-1:0] req_reg;
    logic [POOL_W-1:0] pidx_reg;
    logic [SLOT_W-1:0] sidx_reg;
    logic              quiet_reg;

    // search state
    logic [POOL_W-1:0] p_reg;
    logic              fits_reg;
    logic              got_reg;
    logic [1:0]        gpool_reg;
    logic [SW-1:0]     gslot_reg;

    // occupancy and size table
    logic [POOLS-1:0][SLOTS-1:0] busy_reg;
    logic [SIZE_W-1:0]           mem [DEPTH];
    logic [SIZE_W-1:0]           rdata_reg;

    // output register
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg;

    logic [POOL_W-1:0] np;
    always_comb begin
        np = cfg.pool_count;
        if (np > POOL_W'(NPMAX)) np = POOL_W'(NPMAX);
    end

    assign stat.in_mode  = s_tdata[2:0];
    assign stat.out_free = !m_valid_reg || m_tready;
    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = m_data_reg;

    // one pool of the search per cycle
    logic [SLOTS-1:0] row;
    logic [8:0]       nslots;
    logic             fit;
    logic             found;
    logic [SW-1:0]    free_slot;
    logic             search_stop;

    always_comb begin
        row       = busy_reg[p_reg[PW-1:0]];
        nslots    = slots_of(cfg.slot_counts, p_reg[1:0]);
        fit       = (p_reg < np) && (req_reg != FREE_MARK) &&
                    (cfg.block_size[p_reg[1:0]] >= req_reg);
        found     = 1'b0;
        free_slot = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!row[s] && (9'(s) < nslots)) begin
                found     = 1'b1;
                free_slot = SW'(s);
            end
        end
        search_stop = (req_reg == FREE_MARK) || (p_reg >= np) ||
                      (fit && (found || !cfg.spill_enable));
    end
    assign stat.search_stop = search_stop;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= s_tdata[2:0];
            req_reg   <= s_tdata[18:3];
            pidx_reg  <= s_tdata[21:19];
            sidx_reg  <= s_tdata[29:22];
            quiet_reg <= s_tdata[30];
            p_reg     <= '0;
            fits_reg  <= 1'b0;
            got_reg   <= 1'b0;
        end else if (cmd.step) begin
            if (fit) fits_reg <= 1'b1;
            if (fit && found) begin
                got_reg   <= 1'b1;
                gpool_reg <= p_reg[1:0];
                gslot_reg <= free_slot;
            end
            if (!search_stop) p_reg <= p_reg + 1'b1;
        end
    end

    // addressed slot checks
    logic [8:0]  id_slots;
    logic        id_ok;
    logic        id_busy;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    always_comb begin
        id_slots = slots_of(cfg.slot_counts, pidx_reg[1:0]);
        id_ok    = (pidx_reg < np) && ({1'b0, sidx_reg} < id_slots) &&
                   ((mode_reg == MODE_LOOKUP) ||
                    (cfg.block_size[pidx_reg[1:0]] != '0));
        id_busy  = busy_reg[pidx_reg[PW-1:0]][sidx_reg[SW-1:0]];
        rd_addr  = AW'(pidx_reg[PW-1:0]) * AW'(SLOTS) + AW'(sidx_reg[SW-1:0]);
        wr_addr  = AW'(gpool_reg) * AW'(SLOTS) + AW'(gslot_reg);
    end

    // size table
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.commit && (mode_reg == MODE_RESERVE) && got_reg) begin
            mem[wr_addr] <= req_reg;
        end
    end

    // result assembly
    logic [STAT_W-1:0] r_status;
    logic [POOL_W-1:0] r_pool;
    logic [SLOT_W-1:0] r_slot;
    logic [SIZE_W-1:0] r_size;
    logic              r_rep;
    logic              r_off_en;
    logic [SLOT_W-1:0] mul_s;
    logic [SIZE_W-1:0] mul_b;
    logic [23:0]       product;
    logic [OFF_W-1:0]  r_off;

    always_comb begin
        r_status = ST_ILLEGAL_ID;
        r_pool   = pidx_reg;
        r_slot   = sidx_reg;
        r_size   = '0;
        r_rep    = 1'b0;
        r_off_en = 1'b0;
        mul_s    = sidx_reg;
        mul_b    = cfg.block_size[pidx_reg[1:0]];
        unique case (mode_reg)
            MODE_RESERVE: begin
                r_pool = '0;
                r_slot = '0;
                mul_s  = SLOT_W'(gslot_reg);
                mul_b  = cfg.block_size[gpool_reg];
                if (got_reg) begin
                    r_status = ST_OK;
                    r_pool   = POOL_W'(gpool_reg);
                    r_slot   = SLOT_W'(gslot_reg);
                    r_size   = req_reg;
                    r_off_en = 1'b1;
                end else if (fits_reg) begin
                    r_status = ST_STORE_FULL;
                    r_rep    = !quiet_reg;
                end else begin
                    r_status = ST_TOO_LARGE;
                end
            end
            MODE_LOOKUP, MODE_DELETE: begin
                if (id_ok) begin
                    if (mode_reg == MODE_DELETE) begin
                        r_status = ST_OK;
                        r_off_en = 1'b1;
                    end else if (!id_busy) begin
                        r_status = ST_NOT_PRESENT;
                    end else begin
                        r_status = ST_OK;
                        r_off_en = 1'b1;
                        r_size   = rdata_reg;
                    end
                end
            end
            MODE_CLEAR_POOL: begin
                if (pidx_reg < np) r_status = ST_OK;
            end
            MODE_CLEAR_ALL: begin
                r_status = ST_OK;
                r_pool   = '0;
                r_slot   = '0;
            end
            default: ;
        endcase
        product = 24'(mul_s) * 24'(mul_b);
        r_off   = r_off_en ? product[OFF_W-1:0] : '0;
    end

    // occupancy updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
        end else if (cmd.commit) begin
            case (mode_reg)
                MODE_RESERVE: begin
                    if (got_reg) busy_reg[gpool_reg][gslot_reg] <= 1'b1;
                end
                MODE_DELETE: begin
                    if (id_ok) busy_reg[pidx_reg[PW-1:0]][sidx_reg[SW-1:0]] <= 1'b0;
                end
                MODE_CLEAR_POOL: begin
                    if (pidx_reg < np) busy_reg[pidx_reg[PW-1:0]] <= '0;
                end
                MODE_CLEAR_ALL: busy_reg <= '0;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data_reg <= {3'd0, r_rep, r_size, r_off, r_slot, r_pool, r_status};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/multi_pool_slot_allocator_core.sv =====
// ----------------------------------------------------------------------------
// multi_pool_slot_allocator_core
// Slot bookkeeping for up to four pools of fixed-size blocks.
// ----------------------------------------------------------------------------
// One item is taken at a time. Every item passes an accept state and a hand-over
// state that writes its result to the output register. Reserve adds one search
// step per pool examined: one step per pool up to the pool count, plus a last
// step past the final pool when no pool ends the search. That is one to five
// steps. Lookup adds a state for the registered size table read; the other
// operations go from acceptance straight to hand-over. The search examines one
// pool per cycle with a first-free priority encoder over that pool's occupancy
// bits. A new item is accepted while the previous result still waits in the
// output register; the hand-over state stalls until that result is taken.
// Occupancy bits reset to free at once, so no clearing pass is needed. The user
// must write configuration only while the block is idle; nothing enforces this.
`default_nettype none

module multi_pool_slot_allocator_core #(
    parameter int POOLS = 4,
    parameter int SLOTS = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // mode, request_size, pool_id, slot_index, suppress_fault
    input  wire logic [mpsa_pkg::IN_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // status, granted_pool, granted_slot, byte_offset, stored_size,
    // store_full_report
    output logic      [mpsa_pkg::OUT_W-1:0]  m_tdata,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mpsa_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mpsa_pkg::DATA_W-1:0] pwdata,
    output logic      [mpsa_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import mpsa_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    mpsa_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mpsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mpsa_dp #(
        .POOLS (POOLS),
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mpsa_checker.sv =====
// ----------------------------------------------------------------------------
// mpsa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsa_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [mpsa_pkg::OUT_W-1:0]  m_tdata,
    input wire logic                        pready
);
    import mpsa_pkg::*;

    // a result waits until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    // full report only with store-full status
    a_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[52] |-> m_tdata[2:0] == ST_STORE_FULL)
        else $error("store full report without store full status");

    // failed items carry no offset and no size
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[51:14] == '0)
        else $error("failed item with offset or size");

    // config port never stalls
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind multi_pool_slot_allocator_core mpsa_checker u_mpsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-pool slot allocator core. Items go in on
// the input stream and configuration goes in over the register port. A
// behavioural slot table predicts every result, and each result item is
// checked field by field in order. Directed items come first, then random
// traffic under several register settings and idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import mpsa_pkg::*;

    localparam int  NUM_SLOTS   = 64;
    localparam int  NUM_POOLS   = 4;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  SETTLE      = 12;

    // input item, first field in the lowest bits
    typedef struct packed {
        logic              pad;
        logic              quiet;
        logic [SLOT_W-1:0] slot;
        logic [POOL_W-1:0] pool;
        logic [SIZE_W-1:0] req;
        logic [MODE_W-1:0] mode;
    } alloc_req_t;

    // result item, first field in the lowest bits
    typedef struct packed {
        logic [2:0]        pad;
        logic              full_rep;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  offset;
        logic [SLOT_W-1:0] slot;
        logic [POOL_W-1:0] pool;
        logic [STAT_W-1:0] status;
    } alloc_res_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // shadow of configuration and slot table
    logic [2:0]          sh_pool_count;
    logic                sh_spill;
    logic [SIZE_W-1:0]   sh_block [NUM_POOLS];
    logic [31:0]         sh_slot_counts;
    logic [SIZE_W-1:0]   sh_sizes [NUM_POOLS*NUM_SLOTS];

    alloc_res_t          pending_results[$];
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  error_count = 0;
    int                  cycle_count = 0;

    multi_pool_slot_allocator_core #(
        .POOLS(NUM_POOLS),
        .SLOTS(NUM_SLOTS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // mode, request_size, pool_id, slot_index, suppress_fault
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // status, granted_pool, granted_slot, byte_offset,
                               // stored_size, store_full_report
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int active_pools();
        return (sh_pool_count > NUM_POOLS) ? NUM_POOLS : int'(sh_pool_count);
    endfunction

    function automatic int slots_in_pool(input int p);
        int n;
        n = (sh_slot_counts >> (8 * (p % 4))) & 8'hFF;
        return (n > NUM_SLOTS) ? NUM_SLOTS : n;
    endfunction

    function automatic void free_pool(input int p);
        for (int s = 0; s < NUM_SLOTS; s++) sh_sizes[p*NUM_SLOTS + s] = FREE_MARK;
    endfunction

    // predict the result of one item and update the shadow table
    function automatic alloc_res_t allocate_outcome(input alloc_req_t r);
        alloc_res_t o;
        int         np;
        int         p;
        int         s;
        int         hit_p;
        int         hit_s;
        bit         fits;
        bit         got;
        np = active_pools();
        o = '0;
        o.status = ST_ILLEGAL_ID;
        fits = 0;
        got = 0;
        hit_p = 0;
        hit_s = 0;
        case (r.mode)
            MODE_RESERVE: begin
                if (r.req != FREE_MARK) begin
                    for (p = 0; p < np && !got; p++) begin
                        if (sh_block[p] >= r.req) begin
                            fits = 1;
                            for (s = 0; s < slots_in_pool(p) && !got; s++) begin
                                if (sh_sizes[p*NUM_SLOTS + s] == FREE_MARK) begin
                                    got = 1;
                                    hit_p = p;
                                    hit_s = s;
                                end
                            end
                            if (!got && !sh_spill) break;
                        end
                    end
                end
                if (got) begin
                    sh_sizes[hit_p*NUM_SLOTS + hit_s] = r.req;
                    o.status = ST_OK;
                    o.pool   = POOL_W'(hit_p);
                    o.slot   = SLOT_W'(hit_s);
                    o.offset = OFF_W'(hit_s * int'(sh_block[hit_p]));
                    o.size   = r.req;
                end else if (fits) begin
                    o.status   = ST_STORE_FULL;
                    o.full_rep = !r.quiet;
                end else begin
                    o.status = ST_TOO_LARGE;
                end
            end
            MODE_LOOKUP, MODE_DELETE: begin
                o.pool = r.pool;
                o.slot = r.slot;
                if (r.pool < np && r.slot < slots_in_pool(r.pool) &&
                    (r.mode == MODE_LOOKUP || sh_block[r.pool] != 0)) begin
                    if (r.mode == MODE_DELETE) begin
                        sh_sizes[r.pool*NUM_SLOTS + r.slot] = FREE_MARK;
                        o.status = ST_OK;
                        o.offset = OFF_W'(r.slot * int'(sh_block[r.pool]));
                    end else if (sh_sizes[r.pool*NUM_SLOTS + r.slot] == FREE_MARK) begin
                        o.status = ST_NOT_PRESENT;
                    end else begin
                        o.status = ST_OK;
                        o.offset = OFF_W'(r.slot * int'(sh_block[r.pool]));
                        o.size   = sh_sizes[r.pool*NUM_SLOTS + r.slot];
                    end
                end
            end
            MODE_CLEAR_POOL: begin
                o.pool = r.pool;
                o.slot = r.slot;
                if (r.pool < np) begin
                    free_pool(r.pool);
                    o.status = ST_OK;
                end
            end
            MODE_CLEAR_ALL: begin
                for (p = 0; p < NUM_POOLS; p++) free_pool(p);
                o.status = ST_OK;
            end
            default: begin
                o.pool = r.pool;
                o.slot = r.slot;
            end
        endcase
        return o;
    endfunction

    // result checker, sampled on the falling edge before the accepting edge
    always @(negedge aclk) begin
        alloc_res_t got_res;
        alloc_res_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            got_res = m_tdata;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, m_tdata);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (got_res.status != exp_res.status || got_res.pool != exp_res.pool ||
                    got_res.slot != exp_res.slot || got_res.offset != exp_res.offset ||
                    got_res.size != exp_res.size || got_res.full_rep != exp_res.full_rep ||
                    got_res.pad != 3'b0) begin
                    $display("%0t: mismatch expected st=%0d pool=%0d slot=%0d off=%0d size=%0d rep=%0d",
                             $time, exp_res.status, exp_res.pool, exp_res.slot,
                             exp_res.offset, exp_res.size, exp_res.full_rep);
                    $display("%0t:          actual st=%0d pool=%0d slot=%0d off=%0d size=%0d rep=%0d",
                             $time, got_res.status, got_res.pool, got_res.slot,
                             got_res.offset, got_res.size, got_res.full_rep);
                    error_count++;
                end
            end
        end
    end

    // send one item, predicting at acceptance
    task automatic send_item(input alloc_req_t r);
        bit taken;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        taken = 0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end
        pending_results.push_back(allocate_outcome(r));
    endtask

    task automatic send_op(input logic [MODE_W-1:0] mode, input int req, input int pool,
                           input int slot, input bit quiet);
        alloc_req_t r;
        r.pad   = 1'b0;
        r.quiet = quiet;
        r.slot  = SLOT_W'(slot);
        r.pool  = POOL_W'(pool);
        r.req   = SIZE_W'(req);
        r.mode  = mode;
        send_item(r);
    endtask

    // wait until every result has arrived and the block has settled
    task automatic wait_idle();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // register write, setup then access phase, then an idle phase
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_POOL_COUNT:  sh_pool_count = val[2:0];
            REG_SPILL:       sh_spill = val[0];
            REG_BLOCK_0:     sh_block[0] = val[15:0];
            REG_BLOCK_1:     sh_block[1] = val[15:0];
            REG_BLOCK_2:     sh_block[2] = val[15:0];
            REG_BLOCK_3:     sh_block[3] = val[15:0];
            REG_SLOT_COUNTS: sh_slot_counts = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input int pc, input bit spill, input int b0, input int b1,
                             input int b2, input int b3, input logic [31:0] counts);
        wait_idle();
        write_reg(REG_POOL_COUNT, pc);
        write_reg(REG_SPILL, 32'(spill));
        write_reg(REG_BLOCK_0, b0);
        write_reg(REG_BLOCK_1, b1);
        write_reg(REG_BLOCK_2, b2);
        write_reg(REG_BLOCK_3, b3);
        write_reg(REG_SLOT_COUNTS, counts);
    endtask

    // random item, mostly well formed against the current settings
    function automatic alloc_req_t random_item();
        alloc_req_t r;
        int         pick;
        r = $urandom;
        r.pad = 1'b0;
        pick = $urandom_range(99);
        if (pick < 45)      r.mode = MODE_RESERVE;
        else if (pick < 68) r.mode = MODE_LOOKUP;
        else if (pick < 88) r.mode = MODE_DELETE;
        else if (pick < 93) r.mode = MODE_CLEAR_POOL;
        else if (pick < 95) r.mode = MODE_CLEAR_ALL;
        else if (pick < 98) r.mode = MODE_W'($urandom_range(7, 5));
        if ($urandom_range(9) < 8) begin
            r.pool = POOL_W'($urandom_range(NUM_POOLS - 1));
            r.slot = SLOT_W'($urandom_range(15));
            if ($urandom_range(3) == 0) r.slot = SLOT_W'($urandom_range(NUM_SLOTS - 1));
            case ($urandom_range(3))
                0: r.req = sh_block[r.pool];
                1: r.req = SIZE_W'(int'(sh_block[r.pool]) + 1);
                2: r.req = SIZE_W'($urandom_range(sh_block[r.pool]));
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic int random_block();
        case ($urandom_range(4))
            0: return 0;
            1: return 65534;
            default: return $urandom_range(256);
        endcase
    endfunction

    // extremes of the fields and every operation under reset settings
    task automatic test_directed();
        send_op(MODE_RESERVE, 0, 0, 0, 0);
        send_op(MODE_RESERVE, 16, 0, 0, 0);
        send_op(MODE_RESERVE, 17, 0, 0, 0);
        send_op(MODE_RESERVE, 128, 0, 0, 0);
        send_op(MODE_RESERVE, 129, 0, 0, 0);
        send_op(MODE_RESERVE, 65534, 0, 0, 0);
        send_op(MODE_RESERVE, 65535, 0, 0, 0);
        send_op(MODE_LOOKUP, 0, 0, 1, 0);
        send_op(MODE_LOOKUP, 0, 0, 5, 0);
        send_op(MODE_LOOKUP, 0, 7, 255, 1);
        send_op(MODE_LOOKUP, 0, 3, 64, 0);
        send_op(MODE_DELETE, 0, 0, 1, 0);
        send_op(MODE_DELETE, 0, 0, 1, 0);
        send_op(MODE_LOOKUP, 0, 0, 1, 0);
        send_op(MODE_DELETE, 0, 4, 0, 0);
        send_op(MODE_CLEAR_POOL, 0, 1, 9, 0);
        send_op(MODE_CLEAR_POOL, 0, 5, 0, 0);
        send_op(3'd5, 1, 2, 3, 1);
        send_op(3'd6, 0, 1, 1, 0);
        send_op(3'd7, 65535, 7, 255, 1);
        send_op(MODE_CLEAR_ALL, 0, 0, 0, 0);
        send_op(MODE_LOOKUP, 0, 0, 0, 0);
    endtask

    // full pools, spill, zero-sized pools and counts beyond the slot depth
    task automatic test_pool_limits();
        write_all(2, 0, 8, 0, 99, 99, 32'h00_00_00_02);
        send_op(MODE_RESERVE, 4, 0, 0, 0);
        send_op(MODE_RESERVE, 8, 0, 0, 0);
        send_op(MODE_RESERVE, 1, 0, 0, 0);
        send_op(MODE_RESERVE, 1, 0, 0, 1);
        send_op(MODE_RESERVE, 0, 0, 0, 0);
        send_op(MODE_DELETE, 0, 1, 0, 0);
        send_op(MODE_RESERVE, 50, 0, 0, 0);
        write_all(4, 1, 8, 16, 0, 65534, 32'hFF_00_01_01);
        send_op(MODE_RESERVE, 4, 0, 0, 0);
        send_op(MODE_RESERVE, 4, 0, 0, 0);
        send_op(MODE_RESERVE, 4, 0, 0, 0);
        send_op(MODE_RESERVE, 60000, 0, 0, 0);
        send_op(MODE_LOOKUP, 0, 3, 63, 0);
        send_op(MODE_LOOKUP, 0, 3, 64, 0);
        send_op(MODE_DELETE, 0, 2, 0, 0);
        write_all(1, 1, 0, 16, 32, 64, 32'h40_40_40_40);
        send_op(MODE_RESERVE, 0, 0, 0, 0);
        send_op(MODE_RESERVE, 1, 0, 0, 0);
        send_op(MODE_DELETE, 0, 0, 0, 0);
        send_op(MODE_LOOKUP, 0, 1, 0, 0);
        send_op(MODE_CLEAR_POOL, 0, 1, 0, 0);
        write_all(0, 0, 16, 32, 64, 128, 32'h40_40_40_40);
        send_op(MODE_RESERVE, 1, 0, 0, 0);
        send_op(MODE_LOOKUP, 0, 0, 0, 0);
        send_op(MODE_CLEAR_POOL, 0, 0, 0, 0);
        write_all(7, 1, 16, 32, 64, 128, 32'h40_40_40_40);
        send_op(MODE_LOOKUP, 0, 3, 0, 0);
        send_op(MODE_CLEAR_ALL, 0, 0, 0, 0);
    endtask

    // the sender holds off until each result has come back
    task automatic test_hold_off();
        for (int i = 0; i < 20; i++) begin
            send_item(random_item());
            wait_idle();
        end
    endtask

    // random traffic under one random setting
    task automatic test_random_phase(input int count);
        logic [31:0] counts;
        for (int k = 0; k < 4; k++) counts[8*k +: 8] = ($urandom_range(3) == 0) ?
            8'($urandom_range(255)) : 8'($urandom_range(12));
        write_all($urandom_range(7), 1'($urandom_range(1)), random_block(), random_block(),
                  random_block(), random_block(), counts);
        for (int i = 0; i < count; i++) send_item(random_item());
    endtask

    task automatic test_random(input int snd, input int rcv);
        wait_idle();
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        for (int ph = 0; ph < 4; ph++) test_random_phase(115);
        wait_idle();
        write_all(4, 1'($urandom_range(1)), 16, 32, 64, 128, 32'h40_40_40_40);
        for (int i = 0; i < 20; i++) send_item(random_item());
    endtask

    initial begin
        for (int i = 0; i < NUM_POOLS*NUM_SLOTS; i++) sh_sizes[i] = FREE_MARK;
        sh_pool_count  = 3'd4;
        sh_spill       = 1'b0;
        sh_block[0]    = 16'd16;
        sh_block[1]    = 16'd32;
        sh_block[2]    = 16'd64;
        sh_block[3]    = 16'd128;
        sh_slot_counts = 32'h40_40_40_40;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 13;
        recv_idle_pct = 62;
        test_directed();
        test_pool_limits();
        test_hold_off();
        test_random(13, 62);
        test_random(62, 13);
        test_random(0, 0);
        wait_idle();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/mpsa_pkg.sv
rtl/core/mpsa_cfg.sv
rtl/core/mpsa_ctrl.sv
rtl/core/mpsa_dp.sv
rtl/core/multi_pool_slot_allocator_core.sv
rtl/core/mpsa_checker.sv
tb/testbench.sv
